// ===== rtl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg: shared widths and constants for segment_pair_distance
// Fixed-point widths used by the pipeline stages and the top level.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int CoordW = 24;   // input coordinate, 8 fraction bits
    localparam int DiffW  = 25;   // difference of two coordinates
    localparam int SqW    = 52;   // sum of three squares of DiffW values
    localparam int DotW   = 52;   // signed dot product
    localparam int TW     = 17;   // projection parameter, 16 fraction bits
    localparam int DistW  = 24;   // output distance
    localparam int RootW  = 26;   // square root of a SqW value
    localparam int LimW   = 16;
    localparam int NumPairs = 4;

    localparam logic [LimW-1:0] LimReset = 16'd6;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [DiffW-1:0]  t_diff;

    // one point-to-segment query in flight
    typedef struct packed {
        t_diff [2:0] ab;
        t_diff [2:0] ps;
    } t_query;

endpackage

// ===== rtl/spd_div.sv =====
// ----------------------------------------------------------------------------
// spd_div: pipelined restoring divider for the projection parameter
// One quotient bit per stage; carries the query and an already-decided-t flag along.
// ----------------------------------------------------------------------------
module spd_div
    import spd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  t_query              i_q,
    input  logic [SqW-1:0]      i_len2,
    input  logic signed [DotW-1:0] i_dot,
    input  logic                i_degen,
    output t_query              o_q,
    output logic [TW-1:0]       o_t
);

    localparam int Steps = 16;

    t_query         r_q    [Steps+1];
    logic [TW-1:0]  r_t    [Steps+1];
    logic [SqW-1:0] r_rem  [Steps];
    logic [SqW-1:0] r_den  [Steps];
    logic           r_fix  [Steps];   // t already decided (clamped or degenerate)

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]   <= i_q;
            r_den[0] <= i_len2;
            r_rem[0] <= i_dot[SqW-1:0];
            if (i_degen || i_dot <= 0) begin
                r_fix[0] <= 1'b1;
                r_t[0]   <= '0;
            end else if ($unsigned(i_dot) >= DotW'(i_len2)) begin
                r_fix[0] <= 1'b1;
                r_t[0]   <= TW'(65536);
            end else begin
                r_fix[0] <= 1'b0;
                r_t[0]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [SqW:0] w_sh;
        logic [SqW:0] w_sub;
        logic         w_ge;
        assign w_sh  = {r_rem[k], 1'b0};
        assign w_sub = w_sh - {1'b0, r_den[k]};
        assign w_ge  = w_sh >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1] <= r_q[k];
                if (r_fix[k]) begin
                    r_t[k+1] <= r_t[k];
                end else begin
                    r_t[k+1] <= {r_t[k][TW-2:0], w_ge};
                end
            end
        end
        if (k < Steps - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k+1] <= r_den[k];
                    r_fix[k+1] <= r_fix[k];
                    if (r_fix[k]) begin
                        r_rem[k+1] <= r_rem[k];
                    end else if (w_ge) begin
                        r_rem[k+1] <= w_sub[SqW-1:0];
                    end else begin
                        r_rem[k+1] <= w_sh[SqW-1:0];
                    end
                end
            end
        end
    end

    assign o_q = r_q[Steps];
    assign o_t = r_t[Steps];

endmodule

// ===== rtl/spd_sqrt.sv =====
// ----------------------------------------------------------------------------
// spd_sqrt: pipelined truncating integer square root
// One result bit per stage, restoring digit recurrence.
// ----------------------------------------------------------------------------
module spd_sqrt
    import spd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SqW-1:0]    i_v,
    output logic [RootW-1:0]  o_root
);

    logic [SqW-1:0]   r_v [RootW];
    logic [RootW-1:0] r_r [RootW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0] <= i_v;
            r_r[0] <= '0;
        end
    end

    for (genvar k = 0; k < RootW; k++) begin : g_bit
        localparam int B = RootW - 1 - k;
        logic [RootW-1:0] w_try;
        logic [SqW-1:0]   w_sq;
        logic             w_fit;
        assign w_try = r_r[k] | (RootW'(1) << B);
        // trial square compared against remaining value: (r+2^B)^2 - r^2
        assign w_sq  = (SqW'(r_r[k]) << (B + 1)) + (SqW'(1) << (2 * B));
        assign w_fit = r_v[k] >= w_sq;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k+1] <= w_fit ? w_try : r_r[k];
            end
        end
        if (k < RootW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k+1] <= w_fit ? r_v[k] - w_sq : r_v[k];
                end
            end
        end
    end

    assign o_root = r_r[RootW];

endmodule

// ===== rtl/spd_lane.sv =====
// ----------------------------------------------------------------------------
// spd_lane: one point-to-segment distance pipeline
// Setup products, divider, closest-point offset, squared sum, square root.
// ----------------------------------------------------------------------------
module spd_lane
    import spd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  t_coord [2:0]      i_s,
    input  t_coord [2:0]      i_e,
    input  t_coord [2:0]      i_p,
    input  logic [LimW-1:0]   i_lim,
    output logic [RootW-1:0]  o_dist
);

    // stage 1: differences
    t_query r1_q;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_q.ab[i] <= DiffW'(i_e[i]) - DiffW'(i_s[i]);
                r1_q.ps[i] <= DiffW'(i_p[i]) - DiffW'(i_s[i]);
            end
        end
    end

    // stage 2: per-axis products
    t_query r2_q;
    logic [2*DiffW-1:0]        r2_aa [3];
    logic signed [2*DiffW-1:0] r2_pa [3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_q <= r1_q;
            for (int i = 0; i < 3; i++) begin
                r2_aa[i] <= (2*DiffW)'(r1_q.ab[i]) * (2*DiffW)'(r1_q.ab[i]);
                r2_pa[i] <= (2*DiffW)'(r1_q.ab[i]) * (2*DiffW)'(r1_q.ps[i]);
            end
        end
    end

    // stage 3: sums and degenerate test
    t_query                r3_q;
    logic [SqW-1:0]        r3_len2;
    logic signed [DotW-1:0] r3_dot;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_q    <= r2_q;
            r3_len2 <= SqW'(r2_aa[0]) + SqW'(r2_aa[1]) + SqW'(r2_aa[2]);
            r3_dot  <= DotW'(r2_pa[0]) + DotW'(r2_pa[1]) + DotW'(r2_pa[2]);
        end
    end
    logic w_degen;
    assign w_degen = r3_len2 <= SqW'(i_lim);

    t_query        w_dq;
    logic [TW-1:0] w_t;
    spd_div u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_q    (r3_q),
        .i_len2 (r3_len2),
        .i_dot  (r3_dot),
        .i_degen(w_degen),
        .o_q    (w_dq),
        .o_t    (w_t)
    );

    // stage: |ab| * t
    t_diff [2:0]         r4_ps;
    logic [DiffW+TW-1:0] r4_m [3];
    logic [2:0]          r4_neg;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ps <= w_dq.ps;
            for (int i = 0; i < 3; i++) begin
                r4_neg[i] <= w_dq.ab[i][DiffW-1];
                r4_m[i]   <= (DiffW+TW)'(w_dq.ab[i][DiffW-1] ? -w_dq.ab[i] : w_dq.ab[i])
                             * (DiffW+TW)'(w_t);
            end
        end
    end

    // stage: residual per axis
    logic signed [DiffW+1:0] r5_d [3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_d[i] <= r4_neg[i]
                    ? (DiffW+2)'(r4_ps[i]) + (DiffW+2)'(r4_m[i][DiffW+TW-1:16])
                    : (DiffW+2)'(r4_ps[i]) - (DiffW+2)'(r4_m[i][DiffW+TW-1:16]);
            end
        end
    end

    // stage: squares
    logic [2*(DiffW+2)-1:0] r6_sq [3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r6_sq[i] <= (2*(DiffW+2))'(r5_d[i]) * (2*(DiffW+2))'(r5_d[i]);
            end
        end
    end

    // stage: sum
    logic [SqW-1:0] r7_sum;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_sum <= SqW'(r6_sq[0]) + SqW'(r6_sq[1]) + SqW'(r6_sq[2]);
        end
    end

    spd_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_v   (r7_sum),
        .o_root(o_dist)
    );

endmodule

// ===== rtl/segment_pair_distance.sv =====
// ----------------------------------------------------------------------------
// segment_pair_distance: smallest endpoint-to-segment distance of two segments
//
//  channel  | dir | contents
//  s_axis   | in  | A start/end, B start/end, 12 x 24-bit signed coords
//  m_axis   | out | min_distance, 24-bit unsigned, 8 fraction bits
//  cfg      | in  | degenerate_limit, 16-bit
//
// One word accepted per cycle while the output slot is empty or taken; each
// word passes the setup, divider, offset, sqrt and min tree registers in order.
// The whole pipeline advances while the output slot is empty or taken, so a
// stall on the master side holds every stage and loses nothing.
// Reset clears the valid chain and restores degenerate_limit to 6.
// ----------------------------------------------------------------------------
module segment_pair_distance
    import spd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
    // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z
    input  logic [287:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // min_distance
    output logic [23:0]   m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata
);

    localparam int Lat = 3 + 17 + 4 + 27 + 2;

    logic [LimW-1:0] r_lim;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LimReset;
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_wdata;
        end
    end

    logic [Lat-1:0] r_vld;
    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
        end
    end

    t_coord [2:0] w_as, w_ae, w_bs, w_be;
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign w_as[i] = s_axis_tdata[CoordW*i +: CoordW];
        assign w_ae[i] = s_axis_tdata[CoordW*(3+i) +: CoordW];
        assign w_bs[i] = s_axis_tdata[CoordW*(6+i) +: CoordW];
        assign w_be[i] = s_axis_tdata[CoordW*(9+i) +: CoordW];
    end

    logic [RootW-1:0] w_d [NumPairs];
    spd_lane u_l0 (.i_clk(i_clk), .i_en(w_en), .i_s(w_as), .i_e(w_ae), .i_p(w_bs),
                   .i_lim(r_lim), .o_dist(w_d[0]));
    spd_lane u_l1 (.i_clk(i_clk), .i_en(w_en), .i_s(w_as), .i_e(w_ae), .i_p(w_be),
                   .i_lim(r_lim), .o_dist(w_d[1]));
    spd_lane u_l2 (.i_clk(i_clk), .i_en(w_en), .i_s(w_bs), .i_e(w_be), .i_p(w_as),
                   .i_lim(r_lim), .o_dist(w_d[2]));
    spd_lane u_l3 (.i_clk(i_clk), .i_en(w_en), .i_s(w_bs), .i_e(w_be), .i_p(w_ae),
                   .i_lim(r_lim), .o_dist(w_d[3]));

    logic [RootW-1:0] r_m0, r_m1;
    logic [DistW-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0  <= (w_d[1] < w_d[0]) ? w_d[1] : w_d[0];
            r_m1  <= (w_d[3] < w_d[2]) ? w_d[3] : w_d[2];
            if (r_m0 <= r_m1) begin
                r_out <= (r_m0[RootW-1:DistW] != '0) ? '1 : r_m0[DistW-1:0];
            end else begin
                r_out <= (r_m1[RootW-1:DistW] != '0) ? '1 : r_m1[DistW-1:0];
            end
        end
    end
    assign m_axis_tdata = r_out;

endmodule

// ===== bench/tb_segment_pair_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_pair_distance: self-checking bench for segment_pair_distance
// Drives segment pairs in random and directed shapes and predicts the
// smallest endpoint-to-segment distance of each word. Results are compared
// in order. The degenerate limit is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_segment_pair_distance;
    import spd_pkg::*;

    localparam int Latency  = 53;
    localparam int MaxCycles = 400000;

    typedef logic signed [23:0] t_pt [3];

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [287:0]  s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [23:0]   m_axis_tdata;
    logic          i_cfg_we;
    logic [15:0]   i_cfg_wdata;

    logic [287:0] pending_words[$];
    logic [23:0]  expected_dist[$];
    logic [15:0]  deg_limit;
    int           errors;
    int           cycle_cnt;
    bit           calm;

    segment_pair_distance DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] point_seg_dist(t_pt s, t_pt e, t_pt p);
        logic signed [63:0] ab[3];
        logic signed [63:0] ps[3];
        logic signed [63:0] dot;
        logic signed [63:0] off;
        logic signed [63:0] d;
        logic [63:0] len2;
        logic [63:0] sum;
        logic [63:0] t;
        logic [63:0] rem;
        logic [63:0] mag;
        len2 = 0;
        sum = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            ab[i] = 64'(e[i]) - 64'(s[i]);
            ps[i] = 64'(p[i]) - 64'(s[i]);
            len2 += ab[i] * ab[i];
            dot += ps[i] * ab[i];
        end
        if (len2 <= 64'(deg_limit)) begin
            for (int i = 0; i < 3; i++) sum += ps[i] * ps[i];
            return root_floor(sum);
        end
        if (dot <= 0) begin
            t = 0;
        end else if (64'(dot) >= len2) begin
            t = 65536;
        end else begin
            rem = dot;
            t = 0;
            for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                t = t << 1;
                if (rem >= len2) begin
                    rem = rem - len2;
                    t = t | 1;
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            mag = (ab[i] < 0) ? -ab[i] : ab[i];
            off = (mag * t) >> 16;
            if (ab[i] < 0) off = -off;
            d = ps[i] - off;
            sum += d * d;
        end
        return root_floor(sum);
    endfunction

    function automatic logic [23:0] closest_endpoint_dist(logic [287:0] w);
        t_pt as, ae, bs, be;
        logic [63:0] best;
        logic [63:0] d;
        for (int i = 0; i < 3; i++) begin
            as[i] = w[24*i +: 24];
            ae[i] = w[24*(3+i) +: 24];
            bs[i] = w[24*(6+i) +: 24];
            be[i] = w[24*(9+i) +: 24];
        end
        best = point_seg_dist(as, ae, bs);
        d = point_seg_dist(as, ae, be);
        if (d < best) best = d;
        d = point_seg_dist(bs, be, as);
        if (d < best) best = d;
        d = point_seg_dist(bs, be, ae);
        if (d < best) best = d;
        if (best > 64'hFFFFFF) best = 64'hFFFFFF;
        return best[23:0];
    endfunction

    function automatic logic [23:0] rand_coord(int spread);
        case (spread)
            0: return 24'($urandom_range(0, 7)) - 24'd3;
            1: return 24'($urandom_range(0, 4095)) - 24'd2048;
            2: return 24'($urandom_range(0, 1048575)) - 24'd524288;
            default: return 24'($urandom);
        endcase
    endfunction

    // keep all coordinates in one spread so segments stay near each other;
    // sometimes reuse the A start coordinate of the same axis
    function automatic logic [287:0] rand_pair();
        logic [287:0] w;
        int           spread;
        w = '0;
        spread = $urandom_range(0, 3);
        for (int i = 0; i < 12; i++) begin
            if (spread == 3) begin
                w[24*i +: 24] = 24'($urandom);
            end else if (i >= 3 && $urandom_range(0, 3) == 0) begin
                w[24*i +: 24] = w[24*(i % 3) +: 24];
            end else begin
                w[24*i +: 24] = rand_coord(spread);
            end
        end
        // sometimes B degenerates to a point or A collapses
        if ($urandom_range(0, 9) == 0) w[24*9 +: 72] = w[24*6 +: 72];
        if ($urandom_range(0, 9) == 0) w[24*3 +: 72] = w[24*0 +: 72] + 72'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic enqueue_word(logic [287:0] w);
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_dist.size() != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        deg_limit = v;
    endtask

    // predictor: record the expected result of each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_dist.insert(expected_dist.size(), closest_endpoint_dist(s_axis_tdata));
            void'(pending_words.pop_front());
        end
    end

    // driver: hold a word that is still waiting, else random valid; random ready
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     ((s_axis_tvalid && s_axis_tdata === pending_words[0]) ||
                      calm || $urandom_range(0, 99) >= 26)) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pending_words[0];
        end else begin
            s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= calm || $urandom_range(0, 99) >= 26;
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_dist.size() == 0) begin
                $error("min_distance: no word expected, actual %0d", m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata !== expected_dist[0]) begin
                    $error("min_distance: expected %0d actual %0d",
                           expected_dist[0], m_axis_tdata);
                    errors++;
                end
                void'(expected_dist.pop_front());
            end
        end
        if (cycle_cnt > MaxCycles) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [287:0] w;
        logic [15:0]  limits[5];
        errors        = 0;
        cycle_cnt     = 0;
        calm          = 1'b0;
        deg_limit     = LimReset;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, degenerate, overlapping and far segments
        enqueue_word('0);
        enqueue_word({12{24'h7FFFFF}});
        enqueue_word({12{24'h800000}});
        enqueue_word({{6{24'h7FFFFF}}, {6{24'h800000}}});
        enqueue_word({{3{24'h7FFFFF}}, {3{24'h800000}}, {3{24'h7FFFFF}},
                      {3{24'h800000}}});
        enqueue_word({{3{24'h800000}}, {3{24'h7FFFFF}}, {3{24'h800000}},
                      {3{24'h7FFFFF}}});
        enqueue_word({{6{24'h000100}}, 72'd0, 72'd0});
        enqueue_word({72'd1, 72'd0, 72'd2, 72'd0});
        // B endpoint projects inside A
        enqueue_word({24'd0, 24'd0, 24'd512, 24'd256, 24'd256, 24'd256,
                      24'd0, 24'd0, 24'd4096, 24'd0, 24'd0, 24'd0});
        // beyond each end of A
        enqueue_word({24'd0, 24'd0, 24'hFFF000, 24'd0, 24'd0, 24'h002000,
                      24'd0, 24'd0, 24'd4096, 24'd0, 24'd0, 24'd0});
        // crossing interiors, not detected
        enqueue_word({24'd0, 24'd0, 24'h001000, 24'd0, 24'd0, 24'hFFF000,
                      24'd0, 24'h001000, 24'd0, 24'd0, 24'hFFF000, 24'd0});
        for (int i = 0; i < 8; i++) enqueue_word({$urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        wait_idle();

        limits = '{16'd0, 16'hFFFF, 16'd1, 16'd300, 16'd6};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            calm = (p == 2);
            for (int i = 0; i < 330; i++) begin
                w = rand_pair();
                enqueue_word(w);
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== segment_pair_distance.f =====
rtl/spd_pkg.sv
rtl/spd_div.sv
rtl/spd_sqrt.sv
rtl/spd_lane.sv
rtl/segment_pair_distance.sv
bench/tb_segment_pair_distance.sv
